// File: sv/tgvg_pkg.sv
// Shared constants and types for the torus grid vertex generator.
`timescale 1ns / 1ps
package tgvg_pkg;
    localparam int IndexBitsDefault = 10;
    localparam int CordicSteps = 24;
    localparam int DivSteps = 24;
    localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;
    localparam logic [32:0] TwoPiQ30 = 33'd6746518852;
    localparam logic [1:0] RegRing = 2'd0;
    localparam logic [1:0] RegTube = 2'd1;
    localparam logic [1:0] RegMajor = 2'd2;
    localparam logic [1:0] RegMinor = 2'd3;

    function automatic logic signed [33:0] atan_q30(input int idx);
        logic signed [33:0] v;
        begin
            unique case (idx)
                0: v = 34'sh03243F6A8;
                1: v = 34'sh01DAC6705;
                2: v = 34'sh00FADBAFC;
                3: v = 34'sh007F56EA6;
                4: v = 34'sh003FEAB76;
                5: v = 34'sh001FFD55B;
                6: v = 34'sh000FFFAAA;
                7: v = 34'sh0007FFF55;
                8: v = 34'sh0003FFFEA;
                9: v = 34'sh0001FFFFD;
                10: v = 34'sh0000FFFFF;
                11: v = 34'sh00007FFFF;
                12: v = 34'sh00003FFFF;
                13: v = 34'sh00001FFFF;
                14: v = 34'sh00000FFFF;
                15: v = 34'sh000007FFF;
                16: v = 34'sh000003FFF;
                17: v = 34'sh000001FFF;
                18: v = 34'sh000000FFF;
                19: v = 34'sh0000007FF;
                20: v = 34'sh0000003FF;
                21: v = 34'sh0000001FF;
                22: v = 34'sh0000000FF;
                default: v = 34'sh00000007F;
            endcase
            return v;
        end
    endfunction

    // item state as it moves along the chain
    typedef struct packed {
        logic        vld;
        logic [9:0]  s;
        logic [9:0]  t;
        logic [9:0]  ns;
        logic [9:0]  nt;
        logic [23:0] big_r;
        logic [23:0] small_r;
        // restoring dividers: remainders and quotients
        logic [34:0] rem_a;
        logic [23:0] quo_a;
        logic [34:0] rem_b;
        logic [23:0] quo_b;
        // cordic lanes
        logic [1:0]         qa;
        logic [1:0]         qb;
        logic signed [33:0] xa;
        logic signed [33:0] ya;
        logic signed [33:0] za;
        logic signed [33:0] xb;
        logic signed [33:0] yb;
        logic signed [33:0] zb;
    } t_item;
endpackage

// File: sv/torus_grid_vertex_generator.sv
// Top level: torus grid vertex generator.
`timescale 1ns / 1ps
// One grid point (ring index s, tube index t) in, one vertex out. The item runs
// down a chain of cells: 1 clamp stage, 24 restoring-division cells that form
// both angle fractions s/ns and t/nt of a turn, 1 radian conversion stage,
// 24 CORDIC rotation cells for both angles, and 5 output stages (quadrant fold,
// r*sin and normal products, rho and normals, position multiplies, rounding).
// One item enters every cycle; the whole chain halts
// only while a finished result waits with i_stall high in the output register.
// Indices above the segment counts are clamped; a segment count of zero acts
// as one. Index width is fixed by the package (10 bits).
// Registers (APB, byte address 4*i): ring_segments, tube_segments,
// major_radius, minor_radius. Writes must happen while the chain is empty.
module torus_grid_vertex_generator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [tgvg_pkg::IndexBitsDefault-1:0] i_ring_index,
    input  logic [tgvg_pkg::IndexBitsDefault-1:0] i_tube_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [25:0]    o_pos_x,
    output logic signed [25:0]    o_pos_y,
    output logic signed [25:0]    o_pos_z,
    output logic signed [15:0]    o_norm_x,
    output logic signed [15:0]    o_norm_y,
    output logic signed [15:0]    o_norm_z,
    output logic [16:0]           o_tex_u,
    output logic [16:0]           o_tex_v,
    output logic                  o_quad_valid,
    output logic [19:0]           o_base_index,
    output logic [19:0]           o_next_ring_index
);
    localparam int INDEX_BITS = tgvg_pkg::IndexBitsDefault;
    localparam int NDiv = tgvg_pkg::DivSteps;
    localparam int NCor = tgvg_pkg::CordicSteps;
    localparam int Tail = 5;

    // ---------------- configuration ----------------
    logic [9:0]  r_ring_seg;
    logic [9:0]  r_tube_seg;
    logic [23:0] r_major;
    logic [23:0] r_minor;
    logic [1:0]  w_reg;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_reg  = paddr[3:2];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_seg <= 10'd16;
            r_tube_seg <= 10'd16;
            r_major    <= 24'd65536;
            r_minor    <= 24'd16384;
        end else if (w_wr) begin
            unique case (w_reg)
                tgvg_pkg::RegRing:  r_ring_seg <= pwdata[9:0];
                tgvg_pkg::RegTube:  r_tube_seg <= pwdata[9:0];
                tgvg_pkg::RegMajor: r_major    <= pwdata[23:0];
                default:            r_minor    <= pwdata[23:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            tgvg_pkg::RegRing:  prdata = {22'd0, r_ring_seg};
            tgvg_pkg::RegTube:  prdata = {22'd0, r_tube_seg};
            tgvg_pkg::RegMajor: prdata = {8'd0, r_major};
            default:            prdata = {8'd0, r_minor};
        endcase
    end

    // ---------------- flow control ----------------
    // Whole chain advances unless output holds an item that is stalled.
    logic w_adv;
    logic r_out_vld;
    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;

    // ---------------- clamp stage ----------------
    logic [INDEX_BITS-1:0] w_imask_ns;
    logic [INDEX_BITS-1:0] w_imask_nt;
    logic [INDEX_BITS-1:0] w_ns0;
    logic [INDEX_BITS-1:0] w_nt0;
    logic [INDEX_BITS-1:0] w_sc;
    logic [INDEX_BITS-1:0] w_tc;
    tgvg_pkg::t_item w_in;
    tgvg_pkg::t_item r_c0;

    always_comb begin
        w_imask_ns = r_ring_seg[INDEX_BITS-1:0];
        w_imask_nt = r_tube_seg[INDEX_BITS-1:0];
        w_ns0 = (w_imask_ns == '0) ? INDEX_BITS'(1) : w_imask_ns;
        w_nt0 = (w_imask_nt == '0) ? INDEX_BITS'(1) : w_imask_nt;
        w_sc  = (i_ring_index > w_ns0) ? w_ns0 : i_ring_index;
        w_tc  = (i_tube_index > w_nt0) ? w_nt0 : i_tube_index;
        w_in         = '0;
        w_in.vld     = i_valid;
        w_in.s       = 10'(w_sc);
        w_in.t       = 10'(w_tc);
        w_in.ns      = 10'(w_ns0);
        w_in.nt      = 10'(w_nt0);
        w_in.big_r   = r_major;
        w_in.small_r = r_minor;
        // dividend k*2^24, quotient < 2^24 except at full turn which wraps
        w_in.rem_a   = {1'b0, 10'(w_sc), 24'd0};
        w_in.rem_b   = {1'b0, 10'(w_tc), 24'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0.vld <= 1'b0;
        end else if (w_adv) begin
            r_c0 <= w_in;
        end
    end

    // ---------------- divider chain ----------------
    // Full turn (k == n) would give an all-ones quotient; its angle wraps to
    // zero, so the dividend is cleared and the quotient comes out as 0.
    tgvg_pkg::t_item w_dv [0:NDiv];
    tgvg_pkg::t_item w_full;
    assign w_dv[0] = w_full;

    always_comb begin
        w_full = r_c0;
        if (r_c0.s == r_c0.ns) begin
            w_full.rem_a = '0;
        end
        if (r_c0.t == r_c0.nt) begin
            w_full.rem_b = '0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NDiv; g++) begin : g_div
            tgvg_div_cell #(.STEP(g)) u_div (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_adv  (w_adv),
                .i_item (w_dv[g]),
                .o_item (w_dv[g+1])
            );
        end
    endgenerate

    // ---------------- radian conversion ----------------
    tgvg_pkg::t_item r_rad;
    tgvg_pkg::t_item n_rad;
    logic [54:0] w_za;
    logic [54:0] w_zb;

    always_comb begin
        n_rad = w_dv[NDiv];
        w_za = 55'(w_dv[NDiv].quo_a[21:0]) * 55'(tgvg_pkg::TwoPiQ30);
        w_zb = 55'(w_dv[NDiv].quo_b[21:0]) * 55'(tgvg_pkg::TwoPiQ30);
        n_rad.qa = w_dv[NDiv].quo_a[23:22];
        n_rad.qb = w_dv[NDiv].quo_b[23:22];
        n_rad.za = 34'(w_za >> 24);
        n_rad.zb = 34'(w_zb >> 24);
        n_rad.xa = tgvg_pkg::CordicGain;
        n_rad.xb = tgvg_pkg::CordicGain;
        n_rad.ya = '0;
        n_rad.yb = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad.vld <= 1'b0;
        end else if (w_adv) begin
            r_rad <= n_rad;
        end
    end

    // ---------------- cordic chain ----------------
    tgvg_pkg::t_item w_cr [0:NCor];
    assign w_cr[0] = r_rad;

    generate
        for (g = 0; g < NCor; g++) begin : g_cor
            tgvg_cordic_cell #(.STEP(g)) u_cor (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_adv  (w_adv),
                .i_item (w_cr[g]),
                .o_item (w_cr[g+1])
            );
        end
    endgenerate

    // ---------------- output tail ----------------
    function automatic logic signed [31:0] clamp1(input logic signed [33:0] v);
        logic signed [33:0] c;
        begin
            c = v;
            if (v > 34'sh040000000) c = 34'sh040000000;
            if (v < -34'sh040000000) c = -34'sh040000000;
            return 32'(c);
        end
    endfunction

    function automatic logic signed [25:0] sat26(input logic signed [63:0] v);
        logic signed [25:0] o;
        begin
            if (v > 64'sd33554431) o = 26'sd33554431;
            else if (v < -64'sd33554432) o = -26'sd33554432;
            else o = 26'(v);
            return o;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] o;
        begin
            if (v > 64'sd32767) o = 16'sd32767;
            else if (v < -64'sd32768) o = -16'sd32768;
            else o = 16'(v);
            return o;
        end
    endfunction

    // T1: quadrant fold, texture, indices
    typedef struct packed {
        logic               vld;
        logic signed [31:0] st;
        logic signed [31:0] ct;
        logic signed [31:0] sp;
        logic signed [31:0] cp;
        logic [23:0]        big_r;
        logic [23:0]        small_r;
        logic [16:0]        tu;
        logic [16:0]        tv;
        logic               quad;
        logic [19:0]        base;
        logic [19:0]        nxt;
    } t_tail;

    t_tail r_t1;
    t_tail n_t1;
    logic signed [31:0] w_xa;
    logic signed [31:0] w_ya;
    logic signed [31:0] w_xb;
    logic signed [31:0] w_yb;
    logic [19:0] w_base;

    always_comb begin
        w_xa = clamp1(w_cr[NCor].xa);
        w_ya = clamp1(w_cr[NCor].ya);
        w_xb = clamp1(w_cr[NCor].xb);
        w_yb = clamp1(w_cr[NCor].yb);
        n_t1 = '0;
        n_t1.vld = w_cr[NCor].vld;
        unique case (w_cr[NCor].qa)
            2'd0: begin n_t1.ct = w_xa;  n_t1.st = w_ya;  end
            2'd1: begin n_t1.ct = -w_ya; n_t1.st = w_xa;  end
            2'd2: begin n_t1.ct = -w_xa; n_t1.st = -w_ya; end
            default: begin n_t1.ct = w_ya; n_t1.st = -w_xa; end
        endcase
        unique case (w_cr[NCor].qb)
            2'd0: begin n_t1.cp = w_xb;  n_t1.sp = w_yb;  end
            2'd1: begin n_t1.cp = -w_yb; n_t1.sp = w_xb;  end
            2'd2: begin n_t1.cp = -w_xb; n_t1.sp = -w_yb; end
            default: begin n_t1.cp = w_yb; n_t1.sp = -w_xb; end
        endcase
        n_t1.big_r   = w_cr[NCor].big_r;
        n_t1.small_r = w_cr[NCor].small_r;
        // s*2^16/ns is the top 16 bits of the 24-bit quotient, full turn = 2^16
        n_t1.tu = (w_cr[NCor].s == w_cr[NCor].ns) ? 17'd65536
                : {1'b0, w_cr[NCor].quo_a[23:8]};
        n_t1.tv = (w_cr[NCor].t == w_cr[NCor].nt) ? 17'd0
                : 17'd65536 - {1'b0, w_cr[NCor].quo_b[23:8]};
        w_base = 20'(w_cr[NCor].s) * (20'(w_cr[NCor].nt) + 20'd1)
               + 20'(w_cr[NCor].t);
        n_t1.quad = (w_cr[NCor].s < w_cr[NCor].ns) && (w_cr[NCor].t < w_cr[NCor].nt);
        n_t1.base = w_base;
        n_t1.nxt  = n_t1.quad ? (w_base + 20'(w_cr[NCor].nt) + 20'd1) : 20'd0;
    end

    // T2: r*sp, r*cp, trig products for normals
    typedef struct packed {
        t_tail              b;
        logic signed [56:0] rsp;
        logic signed [56:0] rcp;
        logic signed [63:0] nx;
        logic signed [63:0] nz;
    } t_t2;
    t_t2 r_t2;
    t_t2 n_t2;

    always_comb begin
        n_t2.b   = r_t1;
        n_t2.rsp = 57'($signed({1'b0, r_t1.small_r})) * 57'(r_t1.sp);
        n_t2.rcp = 57'($signed({1'b0, r_t1.small_r})) * 57'(r_t1.cp);
        n_t2.nx  = 64'(r_t1.st) * 64'(r_t1.sp);
        n_t2.nz  = 64'(r_t1.ct) * 64'(r_t1.sp);
    end

    // T3: rho, normals and y
    typedef struct packed {
        t_tail              b;
        logic signed [26:0] rho;
        logic signed [25:0] py;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_t3;
    t_t3 r_t3;
    t_t3 n_t3;

    always_comb begin
        n_t3.b   = r_t2.b;
        n_t3.rho = 27'($signed({1'b0, r_t2.b.big_r}))
                 + 27'((r_t2.rsp + 57'sd536870912) >>> 30);
        n_t3.py  = sat26(-64'((r_t2.rcp + 57'sd536870912) >>> 30));
        n_t3.nx  = sat16((r_t2.nx + 64'sh100000000000) >>> 45);
        n_t3.nz  = sat16((r_t2.nz + 64'sh100000000000) >>> 45);
        n_t3.ny  = sat16(-64'((64'(r_t2.b.cp) + 64'sd16384) >>> 15));
    end

    // T4: rho * trig
    typedef struct packed {
        t_t3                a;
        logic signed [59:0] px;
        logic signed [59:0] pz;
    } t_t4;
    t_t4 r_t4;
    t_t4 n_t4;

    always_comb begin
        n_t4.a  = r_t3;
        n_t4.px = 60'(r_t3.rho) * 60'(r_t3.b.st);
        n_t4.pz = 60'(r_t3.rho) * 60'(r_t3.b.ct);
    end

    // T5: rounding and output register
    logic signed [25:0] r_px;
    logic signed [25:0] r_py;
    logic signed [25:0] r_pz;
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic signed [15:0] r_nz;
    logic [16:0]        r_tu;
    logic [16:0]        r_tv;
    logic               r_quad;
    logic [19:0]        r_base;
    logic [19:0]        r_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.vld   <= 1'b0;
            r_t2.b.vld <= 1'b0;
            r_t3.b.vld <= 1'b0;
            r_t4.a.b.vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (w_adv) begin
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
            r_t4 <= n_t4;
            r_out_vld <= r_t4.a.b.vld;
            r_px   <= sat26(64'((r_t4.px + 60'sd536870912) >>> 30));
            r_pz   <= sat26(64'((r_t4.pz + 60'sd536870912) >>> 30));
            r_py   <= r_t4.a.py;
            r_nx   <= r_t4.a.nx;
            r_ny   <= r_t4.a.ny;
            r_nz   <= r_t4.a.nz;
            r_tu   <= r_t4.a.b.tu;
            r_tv   <= r_t4.a.b.tv;
            r_quad <= r_t4.a.b.quad;
            r_base <= r_t4.a.b.base;
            r_nxt  <= r_t4.a.b.nxt;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_pos_x           = r_px;
    assign o_pos_y           = r_py;
    assign o_pos_z           = r_pz;
    assign o_norm_x          = r_nx;
    assign o_norm_y          = r_ny;
    assign o_norm_z          = r_nz;
    assign o_tex_u           = r_tu;
    assign o_tex_v           = r_tv;
    assign o_quad_valid      = r_quad;
    assign o_base_index      = r_base;
    assign o_next_ring_index = r_nxt;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_base_index)))
        else $error("waiting result changed");
    a_quad_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_quad_valid) |-> (o_next_ring_index == 20'd0))
        else $error("next index set on edge point");
endmodule

// File: sv/tgvg_div_cell.sv
// One restoring-division step for both angle fractions.
`timescale 1ns / 1ps
module tgvg_div_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  tgvg_pkg::t_item     i_item,
    output tgvg_pkg::t_item     o_item
);
    tgvg_pkg::t_item r_item;
    tgvg_pkg::t_item n_item;
    logic [34:0] w_ta;
    logic [34:0] w_tb;
    logic [34:0] w_da;
    logic [34:0] w_db;

    always_comb begin
        n_item = i_item;
        w_da = {1'b0, i_item.ns, 24'd0} >> (STEP + 1);
        w_db = {1'b0, i_item.nt, 24'd0} >> (STEP + 1);
        w_ta = i_item.rem_a - w_da;
        w_tb = i_item.rem_b - w_db;
        if (!w_ta[34]) begin
            n_item.rem_a = w_ta;
        end
        n_item.quo_a = {i_item.quo_a[22:0], ~w_ta[34]};
        if (!w_tb[34]) begin
            n_item.rem_b = w_tb;
        end
        n_item.quo_b = {i_item.quo_b[22:0], ~w_tb[34]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

// File: sv/tgvg_cordic_cell.sv
// One CORDIC rotation step for both angles.
`timescale 1ns / 1ps
module tgvg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  tgvg_pkg::t_item     i_item,
    output tgvg_pkg::t_item     o_item
);
    localparam logic signed [33:0] Atan = tgvg_pkg::atan_q30(STEP);
    tgvg_pkg::t_item r_item;
    tgvg_pkg::t_item n_item;

    always_comb begin
        n_item = i_item;
        if (!i_item.za[33]) begin
            n_item.xa = i_item.xa - (i_item.ya >>> STEP);
            n_item.ya = i_item.ya + (i_item.xa >>> STEP);
            n_item.za = i_item.za - Atan;
        end else begin
            n_item.xa = i_item.xa + (i_item.ya >>> STEP);
            n_item.ya = i_item.ya - (i_item.xa >>> STEP);
            n_item.za = i_item.za + Atan;
        end
        if (!i_item.zb[33]) begin
            n_item.xb = i_item.xb - (i_item.yb >>> STEP);
            n_item.yb = i_item.yb + (i_item.xb >>> STEP);
            n_item.zb = i_item.zb - Atan;
        end else begin
            n_item.xb = i_item.xb + (i_item.yb >>> STEP);
            n_item.yb = i_item.yb - (i_item.xb >>> STEP);
            n_item.zb = i_item.zb + Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule
